FILE: rtl/rmq_pkg.sv
// Shared types and constants for the range-minimum query tree.
package rmq_pkg;

  localparam int VALUE_W = 20;
  localparam int INDEX_W = 11;

  localparam logic [VALUE_W-1:0] EMPTY_MIN = VALUE_W'(1000000);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_QUERY
  } rmq_state_t;

endpackage

FILE: rtl/range_minimum_query_tree_top.sv
// Range-minimum query tree: segment tree in one synchronous memory, one item at a time.
// Items are taken one at a time; in_stall is high while an item is being worked.
// A clear, an ignored append (array full) or an unused action code is done on accept.
// An append writes the leaf on accept, then each level reads the sibling and writes the
// parent, one level per cycle. A query reads tree nodes one at a time through the single
// read port of the node memory as it climbs the levels. An empty or out-of-range query
// returns 1000000.
// The finished result sits in an output register, so the next item is taken while it
// waits; a second query result waits for the first to be taken. The node memory is
// not cleared after reset: a query only reads nodes whose leaves were loaded.
module range_minimum_query_tree_top
  import rmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [INDEX_W-1:0] in_left_index,
  input  logic [INDEX_W-1:0] in_right_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_min_value
);

  localparam int DEPTH  = 2 * MAX_ELEMENTS;
  localparam int NODE_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // node memory
  logic [VALUE_W-1:0] tree_mem [DEPTH];
  logic               mem_we;
  logic [NODE_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [NODE_W-1:0]  mem_raddr;
  logic [VALUE_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= tree_mem[mem_raddr];
    end
  end

  rmq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [VALUE_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0]   lo_r, lo_nxt;
  logic [IDX_W-1:0]   hi_r, hi_nxt;
  logic [VALUE_W-1:0] best_r, best_nxt;
  logic               have_r, have_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_min_r, out_min_nxt;

  logic               in_accept;
  logic [CMP_W-1:0]   first_ext, right_ext, count_ext, last_ext;
  logic               range_ok;
  logic [NODE_W-1:0]  leaf;
  logic [NODE_W-1:0]  parent;
  logic [VALUE_W-1:0] app_min;
  logic               walk_more;
  logic               walk_done;
  logic               out_free;
  logic [VALUE_W-1:0] best_acc;
  logic               have_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // query range clipped to 1..count
  assign count_ext = CMP_W'(count_r);
  assign right_ext = CMP_W'(in_right_index);
  assign first_ext = (in_left_index == '0) ? CMP_W'(1) : CMP_W'(in_left_index);
  assign last_ext  = (right_ext > count_ext) ? count_ext : right_ext;
  assign range_ok  = (first_ext <= last_ext);

  assign leaf    = NODE_W'(MAX_ELEMENTS) + NODE_W'(count_r);
  assign parent  = node_r >> 1;
  assign app_min = (mem_rdata_r < cur_r) ? mem_rdata_r : cur_r;

  assign walk_more = (lo_r < hi_r);
  assign walk_done = !walk_more && !pend_r;
  assign out_free  = !out_valid_r || !out_stall;

  // fold the node read last cycle into the running minimum
  always_comb begin
    best_acc = best_r;
    have_acc = have_r;
    if (pend_r) begin
      best_acc = (have_r && best_r < mem_rdata_r) ? best_r : mem_rdata_r;
      have_acc = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_action == ACT_APPEND && count_r != CNT_W'(MAX_ELEMENTS)) begin
            state_nxt = ST_APPEND;
          end else if (in_action == ACT_QUERY) begin
            state_nxt = ST_QUERY;
          end
        end
      end
      ST_APPEND: begin
        if (parent <= NODE_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (walk_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt     = count_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    pend_nxt      = 1'b0;
    out_min_nxt   = out_min_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_action)
            ACT_CLEAR: count_nxt = '0;
            ACT_APPEND: begin
              if (count_r != CNT_W'(MAX_ELEMENTS)) begin
                mem_we    = 1'b1;
                mem_waddr = leaf;
                mem_wdata = in_value;
                mem_re    = 1'b1;
                mem_raddr = leaf ^ NODE_W'(1);
                node_nxt  = leaf;
                cur_nxt   = in_value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_QUERY: begin
              have_nxt = 1'b0;
              best_nxt = EMPTY_MIN;
              if (range_ok) begin
                lo_nxt = IDX_W'(MAX_ELEMENTS) + IDX_W'(first_ext) - IDX_W'(1);
                hi_nxt = IDX_W'(MAX_ELEMENTS) + IDX_W'(last_ext);
              end else begin
                lo_nxt = '0;
                hi_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_APPEND: begin
        // parent = min(current node, sibling); fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = app_min;
        cur_nxt   = app_min;
        node_nxt  = parent;
        if (parent > NODE_W'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ NODE_W'(1);
        end
      end
      ST_QUERY: begin
        best_nxt = best_acc;
        have_nxt = have_acc;
        if (walk_more) begin
          if (lo_r[0]) begin
            mem_re    = 1'b1;
            mem_raddr = NODE_W'(lo_r);
            pend_nxt  = 1'b1;
            lo_nxt    = lo_r + IDX_W'(1);
          end else if (hi_r[0]) begin
            mem_re    = 1'b1;
            mem_raddr = NODE_W'(hi_r - IDX_W'(1));
            pend_nxt  = 1'b1;
            hi_nxt    = hi_r - IDX_W'(1);
          end else begin
            lo_nxt = lo_r >> 1;
            hi_nxt = hi_r >> 1;
          end
        end else if (walk_done && out_free) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = have_r ? best_r : EMPTY_MIN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    best_r    <= best_nxt;
    have_r    <= have_nxt;
    out_min_r <= out_min_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;

  // loaded count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("loaded count above capacity");

  // a write and a read never hit the same node in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("node memory read and write to the same entry");

  // the query walk bounds never cross
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_QUERY |-> lo_r <= hi_r)
    else $error("query walk bounds crossed");

  // an append climbs only while there is a parent to write
  a_append_node: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPEND |-> node_r > NODE_W'(1))
    else $error("append walk past the root");

endmodule

FILE: sim/tb_range_minimum_query_tree_top.sv
`timescale 1ns / 100ps
// Testbench for the range-minimum query tree: random loads and queries checked by a scan model.
module tb_range_minimum_query_tree_top;
  import rmq_pkg::*;

  localparam int CAPACITY = 1024;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int OPS_PER_PHASE = 60;
  localparam int MAX_INDEX = (1 << INDEX_W) - 1;
  localparam int MAX_VALUE = (1 << VALUE_W) - 1;

  typedef struct packed {
    logic [1:0]         action;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] left_index;
    logic [INDEX_W-1:0] right_index;
  } rmq_op_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_CLEAR;
  logic [VALUE_W-1:0] in_value = '0;
  logic [INDEX_W-1:0] in_left_index = '0;
  logic [INDEX_W-1:0] in_right_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] out_min_value;

  rmq_op_t            pending_ops[$];
  logic [VALUE_W-1:0] expected_mins[$];
  logic [VALUE_W-1:0] loaded_vals[CAPACITY];
  int unsigned        loaded_len = 0;
  int unsigned        gen_len = 0;  // array length as the generator sees it
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatch_count = 0;
  logic               in_taken = 1'b0;

  range_minimum_query_tree_top #(
    .MAX_ELEMENTS(CAPACITY)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_value      (in_value),
    .in_left_index (in_left_index),
    .in_right_index(in_right_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_min_value (out_min_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Plain scan over the loaded positions after clipping to 1..loaded_len.
  function automatic logic [VALUE_W-1:0] predict_range_min(int unsigned first,
                                                           int unsigned last);
    logic [VALUE_W-1:0] best;
    if (first < 1) first = 1;
    if (last > loaded_len) last = loaded_len;
    if (first > last) return EMPTY_MIN;
    best = loaded_vals[first-1];
    for (int unsigned p = first; p < last; p++) begin
      if (loaded_vals[p] < best) best = loaded_vals[p];
    end
    return best;
  endfunction

  task automatic apply_op(logic [1:0] act, logic [VALUE_W-1:0] val,
                          logic [INDEX_W-1:0] lft, logic [INDEX_W-1:0] rgt);
    case (act)
      ACT_CLEAR: loaded_len = 0;
      ACT_APPEND: begin
        if (loaded_len < CAPACITY) begin
          loaded_vals[loaded_len] = val;
          loaded_len++;
        end
      end
      ACT_QUERY: expected_mins.push_back(predict_range_min(32'(lft), 32'(rgt)));
      default: ;
    endcase
  endtask

  always @(negedge clk) begin : drive_inputs
    rmq_op_t op;
    if (!in_valid || in_taken) begin
      if (rst_n && pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        in_action      <= op.action;
        in_value       <= op.value;
        in_left_index  <= op.left_index;
        in_right_index <= op.right_index;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : watch_ports
    logic [VALUE_W-1:0] want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      apply_op(in_action, in_value, in_left_index, in_right_index);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mins.size() == 0) begin
        report_mismatch($sformatf("result %0d with no query waiting", out_min_value));
      end else begin
        want = expected_mins.pop_front();
        if (out_min_value !== want) begin
          report_mismatch($sformatf("min_value %0d, want %0d", out_min_value, want));
        end
      end
    end
  end

  task automatic push_op(logic [1:0] act, int unsigned val, int unsigned lft,
                         int unsigned rgt);
    rmq_op_t op;
    op.action      = act;
    op.value       = VALUE_W'(val);
    op.left_index  = INDEX_W'(lft);
    op.right_index = INDEX_W'(rgt);
    pending_ops.push_back(op);
    case (act)
      ACT_CLEAR:  gen_len = 0;
      ACT_APPEND: if (gen_len < CAPACITY) gen_len++;
      default: ;
    endcase
  endtask

  function automatic int unsigned rand_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(999999, 0);
    if (pick < 85) return $urandom_range(15, 0);  // many ties
    return $urandom_range(MAX_VALUE, 0);
  endfunction

  function automatic int unsigned rand_index();
    return $urandom_range(MAX_INDEX, 0);
  endfunction

  task automatic push_rand_query();
    int unsigned pick, lft, rgt, hi;
    pick = $urandom_range(99);
    hi = (gen_len == 0) ? 1 : gen_len;
    if (pick < 60) begin
      lft = $urandom_range(hi, 1);
      rgt = $urandom_range(hi, lft);
    end else if (pick < 70) begin
      // reversed range
      lft = $urandom_range(hi + 1, 2);
      rgt = $urandom_range(lft - 1, 1);
    end else if (pick < 80) begin
      // starts past the loaded count
      lft = $urandom_range(gen_len + 20, gen_len + 1);
      rgt = $urandom_range(MAX_INDEX, lft);
    end else if (pick < 90) begin
      lft = rand_index();
      rgt = rand_index();
    end else begin
      lft = $urandom_range(1, 0);
      rgt = $urandom_range(MAX_INDEX, hi);
    end
    push_op(ACT_QUERY, rand_value(), lft, rgt);
  endtask

  task automatic push_directed();
    push_op(ACT_QUERY, 0, 1, 1);
    push_op(ACT_UNUSED, MAX_VALUE, MAX_INDEX, MAX_INDEX);
    push_op(ACT_APPEND, MAX_VALUE, 0, 0);
    push_op(ACT_QUERY, 0, 1, 1);
    push_op(ACT_APPEND, 0, MAX_INDEX, MAX_INDEX);
    push_op(ACT_APPEND, 999999, 0, 0);
    push_op(ACT_APPEND, 500000, 0, 0);
    push_op(ACT_APPEND, 7, 0, 0);
    push_op(ACT_QUERY, MAX_VALUE, 0, MAX_INDEX);
    push_op(ACT_QUERY, 0, 1, 5);
    push_op(ACT_QUERY, 0, 3, 5);
    push_op(ACT_QUERY, 0, 5, 5);
    push_op(ACT_QUERY, 0, 2, 2);
    push_op(ACT_QUERY, 0, 6, 9);
    push_op(ACT_QUERY, 0, 4, 2);
    push_op(ACT_QUERY, 0, 5, MAX_INDEX);
    push_op(ACT_QUERY, 0, MAX_INDEX, MAX_INDEX);
    push_op(ACT_QUERY, 0, 0, 0);
    push_op(ACT_CLEAR, MAX_VALUE, MAX_INDEX, MAX_INDEX);
    push_op(ACT_QUERY, 0, 1, 5);
    push_op(ACT_APPEND, 3, 0, 0);
    push_op(ACT_QUERY, 0, 1, 2);
  endtask

  // Load to capacity; the extra appends carry 0 so a stored one would show up.
  task automatic push_full_load();
    push_op(ACT_CLEAR, rand_value(), rand_index(), rand_index());
    for (int i = 0; i < CAPACITY; i++) begin
      push_op(ACT_APPEND, $urandom_range(999999, 1), rand_index(), rand_index());
    end
    push_op(ACT_APPEND, 0, rand_index(), rand_index());
    push_op(ACT_QUERY, 0, 0, MAX_INDEX);
    push_op(ACT_APPEND, 0, rand_index(), rand_index());
    push_op(ACT_QUERY, 0, 1, CAPACITY);
    push_op(ACT_QUERY, 0, CAPACITY, CAPACITY);
    push_op(ACT_QUERY, 0, CAPACITY / 2, CAPACITY);
    push_op(ACT_QUERY, 0, CAPACITY - 1, MAX_INDEX);
    repeat (20) push_rand_query();
  endtask

  task automatic push_random_phase(int unsigned budget);
    int unsigned done_ops, n;
    logic [1:0] act;
    done_ops = 0;
    while (done_ops < budget) begin
      if ($urandom_range(99) < 75) begin
        // fresh array, then queries with a few late appends mixed in
        n = ($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
        push_op(ACT_CLEAR, rand_value(), rand_index(), rand_index());
        repeat (n) push_op(ACT_APPEND, rand_value(), rand_index(), rand_index());
        done_ops += n + 1;
        repeat ($urandom_range(12, 3)) begin
          if ($urandom_range(3) == 0) begin
            push_op(ACT_APPEND, rand_value(), rand_index(), rand_index());
          end else begin
            push_rand_query();
          end
          done_ops++;
        end
      end else begin
        act = 2'($urandom_range(3));
        if (act == ACT_QUERY) begin
          push_rand_query();
        end else begin
          push_op(act, rand_value(), rand_index(), rand_index());
        end
        if (act != ACT_UNUSED) done_ops++;
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_directed();
    push_full_load();
    push_random_phase(OPS_PER_PHASE);
    wait_sent();

    send_idle_pct = 85;
    push_random_phase(OPS_PER_PHASE);
    wait_sent();

    send_idle_pct = 0;
    recv_stall_pct = 85;
    push_random_phase(OPS_PER_PHASE);
    wait_sent();

    send_idle_pct = 28;
    recv_stall_pct = 28;
    push_random_phase(OPS_PER_PHASE);
    wait_sent();

    while (expected_mins.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
